FILE: rtl/core/bhx_pkg.sv
// Shared types and constants for the backslash-x hex escape decoder.
// No dependencies; imported by the other files in rtl/core except bhx_if.
package bhx_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_OK   = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// Decoder phases.
	localparam logic [2:0] PH_NORMAL  = 3'd0;
	localparam logic [2:0] PH_ESC     = 3'd1;
	localparam logic [2:0] PH_HIGH    = 3'd2;
	localparam logic [2:0] PH_LOW     = 3'd3;
	localparam logic [2:0] PH_DISCARD = 3'd4;

	// Characters.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X      = 8'h78;

	// Register map.
	localparam int          PADDR_W     = 3;
	localparam logic [15:0] CAP_RESET   = 16'd256;

	// Decoder state kept between words.
	typedef struct packed {
		logic [2:0] phase;
		logic [3:0] high_nibble;
	} bhx_state_t;

	// One result word as it leaves the decoder.
	typedef struct packed {
		logic        emit;
		logic [1:0]  kind;
		logic [7:0]  out_byte;
		logic [15:0] written_count;
	} bhx_result_t;

	// {valid, value} of an ASCII hex digit, either case.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		priority if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
			return {1'b1, d[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
			return {1'b1, d[3:0]};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
			return {1'b1, d[3:0]};
		end else begin
			return 5'd0;
		end
	endfunction

endpackage

FILE: rtl/core/bhx_if.sv
// Valid/ready channel interfaces for source words and result words.
// Depends on nothing; follows bhx_pkg in compile order.
interface bhx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface bhx_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic [15:0] written_count;
	modport source (output valid, output kind, output out_byte, output written_count,
		input ready);
	modport sink   (input valid, input kind, input out_byte, input written_count,
		output ready);
endinterface

FILE: rtl/core/bhx_decode.sv
// Next-state and result decode for one source byte.
// Depends on bhx_pkg.
module bhx_decode #(
	parameter int COUNT_BITS = 16
) (
	input  bhx_pkg::bhx_state_t  cur,
	input  logic [COUNT_BITS-1:0] count,
	input  logic [7:0]           byte_in,
	input  logic [15:0]          capacity,
	output bhx_pkg::bhx_state_t  nxt,
	output logic [COUNT_BITS-1:0] count_nxt,
	output bhx_pkg::bhx_result_t res
);
	import bhx_pkg::*;

	localparam int LW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	logic [15:0]           limit;
	logic                  full;
	logic [COUNT_BITS-1:0] count_inc;
	logic [COUNT_BITS-1:0] res_count;
	logic [COUNT_BITS+15:0] res_count_ext;
	logic [4:0]            hex;
	logic                  printable;

	assign limit     = (capacity == 16'd0) ? 16'd0 : capacity - 16'd1;
	assign full      = (LW'(count) >= LW'(limit)) || (count == '1);
	assign count_inc = count + {{(COUNT_BITS-1){1'b0}}, 1'b1};
	assign hex       = hex_digit(byte_in);
	assign printable = (byte_in >= CH_SPACE) && (byte_in < CH_DEL);

	always_comb begin
		nxt          = cur;
		count_nxt    = count;
		res.emit     = 1'b0;
		res.kind     = KIND_DATA;
		res.out_byte = 8'd0;
		res_count    = count;

		unique case (cur.phase)
			PH_NORMAL: begin
				priority if (byte_in == CH_NUL) begin
					res.emit  = 1'b1;
					res.kind  = KIND_OK;
					count_nxt = '0;
					nxt.high_nibble = 4'd0;
				end else if (full || (byte_in != CH_BSLASH && !printable)) begin
					res.emit  = 1'b1;
					res.kind  = KIND_ERR;
					count_nxt = '0;
					nxt.high_nibble = 4'd0;
					nxt.phase = PH_DISCARD;
				end else if (byte_in == CH_BSLASH) begin
					nxt.phase = PH_ESC;
				end else begin
					res.emit     = 1'b1;
					res.out_byte = byte_in;
					res_count    = count_inc;
					count_nxt    = count_inc;
				end
			end
			PH_ESC: begin
				priority if (byte_in == CH_BSLASH) begin
					res.emit     = 1'b1;
					res.out_byte = CH_BSLASH;
					res_count    = count_inc;
					count_nxt    = count_inc;
					nxt.phase    = PH_NORMAL;
				end else if (byte_in == CH_X) begin
					nxt.phase = PH_HIGH;
				end else begin
					res.emit  = 1'b1;
					res.kind  = KIND_ERR;
					count_nxt = '0;
					nxt.high_nibble = 4'd0;
					nxt.phase = (byte_in == CH_NUL) ? PH_NORMAL : PH_DISCARD;
				end
			end
			PH_HIGH, PH_LOW: begin
				priority if (hex[4]) begin
					if (cur.phase == PH_HIGH) begin
						nxt.high_nibble = hex[3:0];
						nxt.phase       = PH_LOW;
					end else begin
						res.emit     = 1'b1;
						res.out_byte = {cur.high_nibble, hex[3:0]};
						res_count    = count_inc;
						count_nxt    = count_inc;
						nxt.high_nibble = 4'd0;
						nxt.phase    = PH_NORMAL;
					end
				end else begin
					// terminator here ends the string, anything else starts discarding
					res.emit  = 1'b1;
					res.kind  = KIND_ERR;
					count_nxt = '0;
					nxt.high_nibble = 4'd0;
					nxt.phase = (byte_in == CH_NUL) ? PH_NORMAL : PH_DISCARD;
				end
			end
			default: begin
				if (byte_in == CH_NUL) begin
					nxt.phase       = PH_NORMAL;
					nxt.high_nibble = 4'd0;
					count_nxt       = '0;
				end else begin
					nxt.phase = PH_DISCARD;
				end
			end
		endcase

		res_count_ext     = {16'd0, res_count};
		res.written_count = res_count_ext[15:0];
	end

endmodule

FILE: rtl/core/backslash_hex_escape_decoder_core.sv
// Backslash-x hex escape decoder core: an accepted word passes the input register, then the result register.
// Throughput one source word per cycle: input register, one decode pass, result register.
// A result register that is still waiting stalls the input register, nothing else.
// Reset (arst_n low, asynchronous) clears valids, phase, nibble and count;
// out_capacity returns to 256. Depends on bhx_pkg, bhx_if and bhx_decode.
module backslash_hex_escape_decoder_core #(
	parameter int COUNT_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	bhx_in_if.sink                     item_in,
	bhx_out_if.source                  result_out,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bhx_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import bhx_pkg::*;

	// ---------------------------------------------------------------
	// Configuration: one register, out_capacity, at byte address 0.
	// Bit 2 of paddr selects the word; low bits are byte lanes.
	// ---------------------------------------------------------------
	logic [15:0] capacity_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == 1'b0) ? {16'd0, capacity_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr && paddr[2] == 1'b0) begin
			capacity_q <= pwdata[15:0];
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: input register for the source word.
	// ---------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       out_valid_q;

	// The stage-1 word moves on whenever the result register is free or
	// is being emptied this cycle, even if the word makes no result.
	assign advance       = valid_s1 && (!out_valid_q || result_out.ready);
	assign item_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			byte_s1 <= item_in.in_byte;
		end
	end

	// ---------------------------------------------------------------
	// Decoder state: phase, pending high nibble, bytes written so far.
	// Updated only when the stage-1 word is consumed.
	// ---------------------------------------------------------------
	bhx_state_t            state_q;
	bhx_state_t            state_nxt;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] count_nxt;
	bhx_result_t           res;

	bhx_decode #(
		.COUNT_BITS (COUNT_BITS)
	) u_decode (
		.cur       (state_q),
		.count     (count_q),
		.byte_in   (byte_s1),
		.capacity  (capacity_q),
		.nxt       (state_nxt),
		.count_nxt (count_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= PH_NORMAL;
			state_q.high_nibble <= 4'd0;
			count_q             <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			count_q <= count_nxt;
		end
	end

	// ---------------------------------------------------------------
	// Result register: holds one word until the sink takes it.
	// ---------------------------------------------------------------
	logic [1:0]  kind_q;
	logic [7:0]  out_byte_q;
	logic [15:0] written_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			kind_q          <= res.kind;
			out_byte_q      <= res.out_byte;
			written_count_q <= res.written_count;
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.kind          = kind_q;
	assign result_out.out_byte      = out_byte_q;
	assign result_out.written_count = written_count_q;

endmodule

FILE: rtl/core/bhx_checker.sv
// Port-level checks for the decoder core, attached by bind.
// Depends on bhx_pkg and backslash_hex_escape_decoder_core.
module bhx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  kind,
	input logic [7:0]  out_byte,
	input logic [15:0] written_count
);
	import bhx_pkg::*;

	// only the three defined kinds ever leave the block
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (kind == KIND_DATA || kind == KIND_OK || kind == KIND_ERR))
		else $error("illegal result kind");

	// end words carry no byte
	a_end_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && kind != KIND_DATA) |-> (out_byte == 8'd0))
		else $error("end word with nonzero byte");

	// a data word always counts itself
	a_data_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && kind == KIND_DATA) |-> (written_count != 16'd0))
		else $error("data word with zero count");

	// a stalled word holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=>
			(res_valid && $stable(kind) && $stable(out_byte) && $stable(written_count)))
		else $error("result word changed under stall");

endmodule

bind backslash_hex_escape_decoder_core bhx_checker u_bhx_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result_out.valid),
	.res_ready     (result_out.ready),
	.kind          (result_out.kind),
	.out_byte      (result_out.out_byte),
	.written_count (result_out.written_count)
);

FILE: tb/sv/tb.sv
// Self-checking bench for backslash_hex_escape_decoder_core: source words in, decoded words out.
// Depends on bhx_pkg (result type, codes, register map) and bhx_if (channel interfaces).
module tb;
	import bhx_pkg::*;

	// Run limit in clock cycles.
	localparam int LIMIT_CYCLES = 1_000_000;
	// Cycles to let an in-flight word with no result leave the pipe before a register write.
	localparam int PIPE_FLUSH = 6;
	// Receiver hold-off length, in cycles.
	localparam int HOLD_CYCLES = 300;
	// Chance out of a hundred that a side idles in a given cycle.
	localparam int IDLE_PCT = 28;

	localparam logic [PADDR_W-1:0] ADDR_OUT_CAPACITY = '0;
	localparam logic [7:0] CH_DIGIT0 = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	bhx_in_if in_ch ();
	bhx_out_if out_ch ();

	backslash_hex_escape_decoder_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (in_ch),
		.result_out (out_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// Decoder model state; starts at its reset values since reset is applied only once.
	logic [2:0] ph_model = PH_NORMAL;
	logic [3:0] nib_model = 4'd0;
	logic [15:0] cnt_model = 16'd0;
	logic [15:0] cap_model = CAP_RESET;

	bhx_result_t dec_expect[$];   // decoded words still owed by the block
	logic [7:0] src_bytes[$];     // source words waiting for the driver

	int n_gen = 0;       // source words generated so far
	int n_offered = 0;   // source words put on the input channel
	int n_taken = 0;     // source words accepted by the block
	int n_words = 0;     // decoded words received
	int n_err = 0;
	int n_cycles = 0;

	logic quiet = 1'b0;     // no idling on either side while set
	logic hold_go = 1'b0;   // arms the receiver hold-off
	logic rx_hold = 1'b0;   // receiver holds ready low while set

	// ---------------------------------------------------------------
	// Decoder model
	// ---------------------------------------------------------------

	// {is_hex, value} of a source word; both letter cases count.
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= CH_DIGIT0 && c <= CH_DIGIT0 + 8'd9)
			return {1'b1, c[3:0]};
		if ((c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) ||
				(c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5))
			return {1'b1, c[3:0] + 4'd9};
		return 5'd0;
	endfunction

	// End of string: the word carries the total, counters clear for the next string.
	function automatic bhx_result_t close_string(input logic [1:0] k, input logic [2:0] nxt);
		bhx_result_t r;
		r = '0;
		r.emit = 1'b1;
		r.kind = k;
		r.written_count = cnt_model;
		cnt_model = 16'd0;
		nib_model = 4'd0;
		ph_model = nxt;
		return r;
	endfunction

	function automatic bhx_result_t emit_byte(input logic [7:0] b);
		bhx_result_t r;
		cnt_model = cnt_model + 16'd1;
		ph_model = PH_NORMAL;
		r.emit = 1'b1;
		r.kind = KIND_DATA;
		r.out_byte = b;
		r.written_count = cnt_model;
		return r;
	endfunction

	// One source word through the model; emit clear means no decoded word.
	function automatic bhx_result_t decode_step(input logic [7:0] c);
		bhx_result_t r;
		logic [4:0] h;
		logic [15:0] lim;
		r = '0;
		h = nibble_of(c);
		// capacity 0 behaves like 1: nothing fits
		lim = (cap_model == 16'd0) ? 16'd0 : cap_model - 16'd1;
		case (ph_model)
			PH_NORMAL: begin
				if (c == CH_NUL)
					r = close_string(KIND_OK, PH_NORMAL);
				else if (cnt_model >= lim || cnt_model == '1)
					r = close_string(KIND_ERR, PH_DISCARD);   // full, checked first
				else if (c == CH_BSLASH)
					ph_model = PH_ESC;
				else if (c < CH_SPACE || c >= CH_DEL)
					r = close_string(KIND_ERR, PH_DISCARD);
				else
					r = emit_byte(c);
			end
			PH_ESC: begin
				if (c == CH_NUL)
					r = close_string(KIND_ERR, PH_NORMAL);
				else if (c == CH_BSLASH)
					r = emit_byte(CH_BSLASH);
				else if (c == CH_X)
					ph_model = PH_HIGH;
				else
					r = close_string(KIND_ERR, PH_DISCARD);
			end
			PH_HIGH, PH_LOW: begin
				if (c == CH_NUL)
					r = close_string(KIND_ERR, PH_NORMAL);
				else if (!h[4])
					r = close_string(KIND_ERR, PH_DISCARD);
				else if (ph_model == PH_HIGH) begin
					nib_model = h[3:0];
					ph_model = PH_LOW;
				end else begin
					r = emit_byte({nib_model, h[3:0]});
					nib_model = 4'd0;
				end
			end
			default: begin
				// discarding: silent up to and including the next NUL
				if (c == CH_NUL) begin
					ph_model = PH_NORMAL;
					cnt_model = 16'd0;
					nib_model = 4'd0;
				end
			end
		endcase
		return r;
	endfunction

	task automatic report(input string msg);
		n_err++;
		if (n_err <= 40)
			$display("MISMATCH: %s", msg);
	endtask

	// ---------------------------------------------------------------
	// Clock, reset, run limit
	// ---------------------------------------------------------------

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > LIMIT_CYCLES) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Input driver: one source word per handshake, fed from src_bytes.
	// A word stays on the bus until it has been taken.
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (in_ch.valid && n_taken != n_offered) begin
			// still waiting for ready
		end else if (src_bytes.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
			in_ch.in_byte <= src_bytes.pop_front();
			in_ch.valid <= 1'b1;
			n_offered <= n_offered + 1;
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	// Output ready: random stalls, none when quiet, held low during the hold-off.
	always @(negedge clk) begin
		if (!arst_n || rx_hold)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
	end

	// Receiver hold-off: once armed and words are queued, ready stays low long
	// enough for the pipe to fill and push back on the input.
	initial begin
		wait (hold_go && src_bytes.size() > 0);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	// ---------------------------------------------------------------
	// Monitor: accepted source words go through the model, decoded words are
	// checked against the oldest expectation.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : mon
		bhx_result_t r;
		bhx_result_t want;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				r = decode_step(in_ch.in_byte);
				if (r.emit)
					dec_expect.push_back(r);
				n_taken <= n_taken + 1;
			end
			if (out_ch.valid && out_ch.ready) begin
				n_words++;
				if (dec_expect.size() == 0) begin
					report($sformatf("word %0d arrived with none expected (kind %0d byte %02h count %0d)",
						n_words, out_ch.kind, out_ch.out_byte, out_ch.written_count));
				end else begin
					want = dec_expect.pop_front();
					if (out_ch.kind !== want.kind)
						report($sformatf("word %0d kind %0d, want %0d",
							n_words, out_ch.kind, want.kind));
					if (out_ch.out_byte !== want.out_byte)
						report($sformatf("word %0d out_byte %02h, want %02h",
							n_words, out_ch.out_byte, want.out_byte));
					if (out_ch.written_count !== want.written_count)
						report($sformatf("word %0d written_count %0d, want %0d",
							n_words, out_ch.written_count, want.written_count));
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Register access and stimulus helpers
	// ---------------------------------------------------------------

	task automatic cfg_write(input logic [15:0] v);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_OUT_CAPACITY;
		pwdata <= {16'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		cap_model = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic cfg_check(input logic [15:0] v);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= ADDR_OUT_CAPACITY;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[15:0] !== v)
			report($sformatf("out_capacity reads %0d, want %0d", prdata[15:0], v));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Sender pause: everything taken and every owed word received, then a
	// flush wait for a trailing word that owes nothing.
	task automatic wait_drained();
		@(posedge clk);
		while (src_bytes.size() != 0 || n_taken != n_offered || dec_expect.size() != 0)
			@(posedge clk);
		repeat (PIPE_FLUSH) @(posedge clk);
	endtask

	task automatic put(input logic [7:0] b);
		src_bytes.push_back(b);
		n_gen++;
	endtask

	function automatic logic [7:0] hex_char();
		logic [7:0] v;
		v = 8'($urandom_range(15));
		if (v < 8'd10)
			return CH_DIGIT0 + v;
		return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + v - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex();
		logic [7:0] b;
		logic [4:0] h;
		b = 8'($urandom_range(255, 1));
		h = nibble_of(b);
		while (h[4]) begin
			b = 8'($urandom_range(255, 1));
			h = nibble_of(b);
		end
		return b;
	endfunction

	// Printable and not a backslash.
	function automatic logic [7:0] plain_char();
		logic [7:0] b;
		b = 8'($urandom_range(126, 32));
		while (b == CH_BSLASH)
			b = 8'($urandom_range(126, 32));
		return b;
	endfunction

	// A broken string tail: one fault, then junk up to a NUL unless the
	// fault itself is a NUL inside an escape.
	task automatic gen_fault();
		logic [7:0] b;
		int k;
		int m;
		k = $urandom_range(4);
		case (k)
			0: begin
				b = $urandom_range(1) ? 8'($urandom_range(31, 1)) : 8'($urandom_range(255, 127));
				put(b);
			end
			1: begin
				b = 8'($urandom_range(255, 1));
				while (b == CH_BSLASH || b == CH_X)
					b = 8'($urandom_range(255, 1));
				put(CH_BSLASH);
				put(b);
			end
			2: begin
				put(CH_BSLASH);
				put(CH_X);
				put(non_hex());
			end
			3: begin
				put(CH_BSLASH);
				put(CH_X);
				put(hex_char());
				put(non_hex());
			end
			default: begin
				// NUL inside an escape ends the string itself
				put(CH_BSLASH);
				m = $urandom_range(2);
				if (m > 0)
					put(CH_X);
				if (m > 1)
					put(hex_char());
			end
		endcase
		if (k < 4) begin
			repeat ($urandom_range(3)) begin
				b = 8'($urandom_range(255, 1));
				put(b);
			end
		end
		put(CH_NUL);
	endtask

	// Mostly well-formed strings with random content; one in five breaks somewhere.
	task automatic gen_string(input int max_tok);
		int n_tok;
		int fault_at;
		int k;
		n_tok = $urandom_range(max_tok);
		fault_at = ($urandom_range(99) < 20) ? $urandom_range(n_tok) : -1;
		for (k = 0; k < n_tok && k != fault_at; k++) begin
			case ($urandom_range(9))
				0: begin
					put(CH_BSLASH);
					put(CH_BSLASH);
				end
				1, 2, 3: begin
					put(CH_BSLASH);
					put(CH_X);
					put(hex_char());
					put(hex_char());
				end
				default: put(plain_char());
			endcase
		end
		if (fault_at >= 0)
			gen_fault();
		else
			put(CH_NUL);
	endtask

	// Raw noise: any nonzero words, then a NUL.
	task automatic gen_noise();
		logic [7:0] b;
		repeat ($urandom_range(6)) begin
			b = 8'($urandom_range(255, 1));
			put(b);
		end
		put(CH_NUL);
	endtask

	task automatic run_phase(input logic [15:0] cap, input int n_bytes, input int max_tok);
		int stop;
		cfg_write(cap);
		cfg_check(cap);
		stop = n_gen + n_bytes;
		while (n_gen < stop) begin
			if ($urandom_range(9) == 0)
				gen_noise();
			else
				gen_string(max_tok);
		end
		wait_drained();
	endtask

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'd0;
		out_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = 32'd0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset value of the capacity register
		cfg_check(CAP_RESET);

		// Directed words at reset capacity.
		// Printable extremes, escaped backslash, mixed-case hex escape, clean end.
		put(CH_SPACE);
		put(CH_TILDE);
		put(CH_BSLASH);
		put(CH_BSLASH);
		put(CH_BSLASH);
		put(CH_X);
		put("a");
		put("F");
		put(CH_NUL);
		// DEL is unprintable; following junk is discarded silently
		put(CH_DEL);
		put(8'hFF);
		put(CH_NUL);
		// control character just below space
		put(8'h1F);
		put(CH_NUL);
		// bad escape
		put(CH_BSLASH);
		put("q");
		put(CH_NUL);
		// bad hex digit
		put(CH_BSLASH);
		put(CH_X);
		put("G");
		put(CH_NUL);
		// NUL right after a backslash, and after the first hex digit
		put(CH_BSLASH);
		put(CH_NUL);
		put(CH_BSLASH);
		put(CH_X);
		put("9");
		put(CH_NUL);
		wait_drained();

		// Capacity 1 and 0: no data word fits, so any nonzero word is an overrun.
		run_phase(16'd1, 100, 3);
		run_phase(16'd0, 60, 3);

		// Random phases: small capacities overrun often, large ones rarely.
		run_phase(16'd2, 150, 4);
		run_phase(16'd8, 200, 12);

		// Back-to-back stretch with no idling on either side.
		quiet = 1'b1;
		run_phase(16'd30, 200, 40);
		quiet = 1'b0;

		// Receiver stalls long enough for the block to back up its input.
		hold_go = 1'b1;
		run_phase(16'd256, 250, 20);

		run_phase(16'hFFFF, 150, 20);
		repeat (3)
			run_phase(16'($urandom_range(64, 1)), 80, 24);

		// Pipe is idle; anything still owed never arrived.
		repeat (PIPE_FLUSH) @(posedge clk);
		if (dec_expect.size() != 0)
			report($sformatf("%0d decoded words never arrived", dec_expect.size()));
		if (n_err == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
